>>> design/rpdmd_pkg.sv
package rpdmd_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ErrW     = 18;
  localparam int unsigned SumW     = 34;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SETPOINT  = 3'd0,
    REG_GAIN_PROP = 3'd1,
    REG_GAIN_DERIV = 3'd2,
    REG_MIN_SUPPLY = 3'd3,
    REG_WIDTH_MIN = 3'd4,
    REG_WIDTH_MAX = 3'd5,
    REG_WIDTH_NEUTRAL = 3'd6
  } cfg_idx_t;

  localparam logic [7:0]  SetpointRst     = 8'd50;
  localparam logic [13:0] GainPropRst     = 14'd0;
  localparam logic [13:0] GainDerivRst    = 14'd0;
  localparam logic [10:0] MinSupplyRst    = 11'd6;
  localparam logic [15:0] WidthMinRst     = 16'd2028;
  localparam logic [15:0] WidthMaxRst     = 16'd3502;
  localparam logic [15:0] WidthNeutralRst = 16'd2765;
  localparam logic [15:0] CompareTop      = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  setpoint_range;
    logic [13:0] gain_prop;
    logic [13:0] gain_deriv;
    logic [10:0] min_supply;
    logic [15:0] width_min;
    logic [15:0] width_max;
    logic [15:0] width_neutral;
  } cfg_t;

  typedef struct packed {
    logic        loop_enable;
    logic [15:0] range_reading;
    logic [10:0] supply_volts;
  } tick_t;

  typedef struct packed {
    logic                   locked_out;
    logic [15:0]            pulse_width;
    logic                   err_update;
    logic signed [ErrW-1:0] err;
  } law_out_t;

endpackage

>>> design/rpdmd_law.sv
module rpdmd_law (
  input  rpdmd_pkg::cfg_t                     cfg,
  input  rpdmd_pkg::tick_t                    tick,
  input  logic                                latch,
  input  logic signed [rpdmd_pkg::ErrW-1:0]   prev_err,
  output rpdmd_pkg::law_out_t                 res
);
  import rpdmd_pkg::*;

  logic                   lock_now;
  logic signed [ErrW-1:0] err;
  logic signed [ErrW-1:0] diff;
  logic signed [SumW-2:0] p_term;
  logic signed [SumW-2:0] d_term;
  logic signed [SumW-1:0] sum;
  logic signed [SumW-1:0] wmax_s;
  logic signed [SumW-1:0] wmin_s;
  logic signed [SumW-1:0] clamped;

  assign lock_now = latch || (tick.supply_volts < cfg.min_supply);
  assign err  = $signed({{(ErrW-8){1'b0}}, cfg.setpoint_range})
              - $signed({{(ErrW-16){1'b0}}, tick.range_reading});
  assign diff = err - prev_err;

  assign p_term = $signed({1'b0, cfg.gain_prop}) * err;
  assign d_term = $signed({1'b0, cfg.gain_deriv}) * diff;
  assign sum    = SumW'(p_term) + SumW'(d_term);

  assign wmax_s = $signed({{(SumW-16){1'b0}}, cfg.width_max});
  assign wmin_s = $signed({{(SumW-16){1'b0}}, cfg.width_min});

  always_comb begin
    clamped = sum;
    if (clamped > wmax_s) begin
      clamped = wmax_s;
    end
    if (clamped < wmin_s) begin
      clamped = wmin_s;
    end
  end

  always_comb begin
    res.locked_out = lock_now;
    res.err        = err;
    res.err_update = 1'b0;
    if (lock_now) begin
      res.pulse_width = cfg.width_min;
    end else if (!tick.loop_enable) begin
      res.pulse_width = cfg.width_neutral;
    end else begin
      res.pulse_width = clamped[15:0];
      res.err_update  = 1'b1;
    end
  end

endmodule

>>> design/range_pd_motor_drive_core.sv
// PD range-holding motor drive, one control tick per input beat.
// Slave stream s_*: one beat per tick, tdata = {supply_volts, range_reading,
// loop_enable}. Master stream m_*: one beat per tick, tdata = {locked_out,
// compare_load, pulse_width}. Configuration goes through cfg_we/cfg_addr/
// cfg_data; the user must write it only while no tick is in flight, which the
// block does not enforce. Register order is setpoint, kp, kd, min supply,
// width min, width max, width neutral. A beat accepted into the input register
// moves to the result register once that is empty or being read, and is
// presented on m_tvalid from there. Throughput is one beat per cycle while
// m_tready is high; the control law (two 15x18 multiplies, add, clamp) sits
// between the input register and the result register, and only the stored
// error and the lockout latch feed back from one tick to the next.
// A supply reading below min supply latches a lockout; every later tick
// returns width min until reset.
// Reset restores the default gains and limits, clears the stored error and
// the lockout, and empties both registers. When m_tready is low the result
// holds, the input register fills, and s_tready drops once both are full.
module range_pd_motor_drive_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [0] loop_enable, [16:1] range_reading, [27:17] supply_volts, rest zero
  input  logic [rpdmd_pkg::InDataW-1:0]       s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [15:0] pulse_width, [31:16] compare_load, [32] locked_out, rest zero
  output logic [rpdmd_pkg::OutDataW-1:0]      m_tdata,
  input  logic                                cfg_we,
  input  logic [rpdmd_pkg::CfgIdxW-1:0]       cfg_addr,
  input  logic [rpdmd_pkg::CfgDataW-1:0]      cfg_data
);
  import rpdmd_pkg::*;

  cfg_t                   cfg;
  tick_t                  in_tick;
  logic                   in_valid;
  logic                   out_valid;
  logic [15:0]            out_pw;
  logic                   out_lock;
  logic                   latch;
  logic signed [ErrW-1:0] prev_err;
  logic                   out_load;
  logic                   in_load;
  law_out_t               law;

  assign out_load = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || out_load;
  assign in_load  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint_range <= SetpointRst;
      cfg.gain_prop      <= GainPropRst;
      cfg.gain_deriv     <= GainDerivRst;
      cfg.min_supply     <= MinSupplyRst;
      cfg.width_min      <= WidthMinRst;
      cfg.width_max      <= WidthMaxRst;
      cfg.width_neutral  <= WidthNeutralRst;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SETPOINT:      cfg.setpoint_range <= cfg_data[7:0];
        REG_GAIN_PROP:     cfg.gain_prop      <= cfg_data[13:0];
        REG_GAIN_DERIV:    cfg.gain_deriv     <= cfg_data[13:0];
        REG_MIN_SUPPLY:    cfg.min_supply     <= cfg_data[10:0];
        REG_WIDTH_MIN:     cfg.width_min      <= cfg_data;
        REG_WIDTH_MAX:     cfg.width_max      <= cfg_data;
        REG_WIDTH_NEUTRAL: cfg.width_neutral  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_load) begin
      in_valid <= 1'b1;
    end else if (out_load) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_tick.loop_enable   <= s_tdata[0];
      in_tick.range_reading <= s_tdata[16:1];
      in_tick.supply_volts  <= s_tdata[27:17];
    end
  end

  rpdmd_law u_law (
    .cfg      (cfg),
    .tick     (in_tick),
    .latch    (latch),
    .prev_err (prev_err),
    .res      (law)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      latch    <= 1'b0;
      prev_err <= '0;
    end else if (out_load) begin
      latch <= law.locked_out;
      if (law.err_update) begin
        prev_err <= law.err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pw   <= law.pulse_width;
      out_lock <= law.locked_out;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OutDataW-33){1'b0}}, out_lock, CompareTop - out_pw, out_pw};

endmodule

>>> dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rpdmd_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;
  localparam int unsigned TicksPerPhase = 170;
  localparam int unsigned HoldAtTick = 300;
  localparam int unsigned HoldCycles = 90;

  typedef struct packed {
    logic [15:0] pulse_width;
    logic [15:0] compare_load;
    logic        locked_out;
  } drive_result_t;

  class pd_drive_predictor;
    int setpoint, gain_prop, gain_deriv, min_supply;
    int width_min, width_max, width_neutral;
    int last_err;
    bit locked;
    drive_result_t pending_results[$];
    int n_ticks, n_beats, n_bad;
    int n_lock, n_neutral, n_hi, n_lo, n_linear;

    function new();
      setpoint      = SetpointRst;
      gain_prop     = GainPropRst;
      gain_deriv    = GainDerivRst;
      min_supply    = MinSupplyRst;
      width_min     = WidthMinRst;
      width_max     = WidthMaxRst;
      width_neutral = WidthNeutralRst;
      last_err = 0;
      locked = 1'b0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        REG_SETPOINT:      setpoint = val[7:0];
        REG_GAIN_PROP:     gain_prop = val[13:0];
        REG_GAIN_DERIV:    gain_deriv = val[13:0];
        REG_MIN_SUPPLY:    min_supply = val[10:0];
        REG_WIDTH_MIN:     width_min = val;
        REG_WIDTH_MAX:     width_max = val;
        REG_WIDTH_NEUTRAL: width_neutral = val;
        default: ;
      endcase
    endfunction

    function void note_tick(logic en, logic [15:0] rng, logic [10:0] volts);
      drive_result_t r;
      int err;
      longint sum;
      n_ticks++;
      if (int'(volts) < min_supply) locked = 1'b1;
      if (locked) begin
        r.pulse_width = width_min[15:0];
        n_lock++;
      end else if (!en) begin
        r.pulse_width = width_neutral[15:0];
        n_neutral++;
      end else begin
        err = setpoint - int'(rng);
        sum = longint'(gain_prop) * err + longint'(gain_deriv) * (err - last_err);
        if (sum > longint'(width_max)) begin
          sum = width_max;
          n_hi++;
        end else if (sum >= longint'(width_min)) begin
          n_linear++;
        end
        if (sum < longint'(width_min)) begin
          sum = width_min;
          n_lo++;
        end
        last_err = err;
        r.pulse_width = sum[15:0];
      end
      r.compare_load = CompareTop - r.pulse_width;
      r.locked_out = locked;
      pending_results.push_back(r);
    endfunction

    function void check_beat(logic [OutDataW-1:0] d);
      drive_result_t want;
      n_beats++;
      if (pending_results.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("%0t: result beat with nothing pending: %h", $realtime, d);
        return;
      end
      want = pending_results.pop_front();
      if (d[15:0] !== want.pulse_width || d[31:16] !== want.compare_load ||
          d[32] !== want.locked_out) begin
        n_bad++;
        if (n_bad <= 10)
          $display("%0t: beat %0d pw exp %0d got %0d, load exp %0d got %0d, lock exp %b got %b",
                   $realtime, n_beats, want.pulse_width, d[15:0], want.compare_load,
                   d[31:16], want.locked_out, d[32]);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InDataW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  pd_drive_predictor drive_pred = new();
  bit calm = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  always #4 clk = ~clk;

  range_pd_motor_drive_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) drive_pred.check_beat(m_tdata);
      if (!hold_done && drive_pred.n_ticks >= HoldAtTick) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(99) < 11) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_tick(input logic en, input logic [15:0] rng, input logic [10:0] volts);
    if (!calm && $urandom_range(99) < 11) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata <= {{(InDataW - 28){1'b0}}, volts, rng, en};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    drive_pred.note_tick(en, rng, volts);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (drive_pred.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    drive_pred.write_reg(idx, val);
  endtask

  task automatic apply_cfg(input logic [15:0] sp, input logic [15:0] kp,
                           input logic [15:0] kd, input logic [15:0] ms,
                           input logic [15:0] wmin, input logic [15:0] wmax,
                           input logic [15:0] wneu);
    write_reg(REG_SETPOINT, sp);
    write_reg(REG_GAIN_PROP, kp);
    write_reg(REG_GAIN_DERIV, kd);
    write_reg(REG_MIN_SUPPLY, ms);
    write_reg(REG_WIDTH_MIN, wmin);
    write_reg(REG_WIDTH_MAX, wmax);
    write_reg(REG_WIDTH_NEUTRAL, wneu);
    // unmapped index, must leave every register alone
    write_reg(REG_UNUSED, 16'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int rng;
    logic [15:0] sp, kp, kd, ms, wa, wb, wmin, wmax;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: zero gains, stock limits, threshold edge
    send_tick(1'b1, 16'd50, 11'd1080);
    send_tick(1'b0, 16'd7, 11'd6);
    send_tick(1'b1, 16'd0, 11'd6);
    wait_drained();

    // large gains, open limits; wide setpoint write keeps the low byte
    apply_cfg(16'hFFFF, 16'd9999, 16'd9999, 16'd0, 16'd0, 16'hFFFF, 16'd0);
    send_tick(1'b1, 16'd0, 11'd0);
    send_tick(1'b1, 16'hFFFF, 11'd1080);
    send_tick(1'b0, 16'hFFFF, 11'd1023);
    send_tick(1'b1, 16'd255, 11'd1024);
    wait_drained();

    // small gains, results inside the window and clamped low; gain write has junk upper bits
    apply_cfg(16'hFF64, 16'hC003, 16'd2, 16'd0, 16'd100, 16'd1000, 16'hFFFF);
    send_tick(1'b1, 16'd100, 11'd512);
    send_tick(1'b1, 16'd40, 11'd300);
    send_tick(1'b1, 16'd0, 11'd700);
    send_tick(1'b1, 16'd160, 11'd85);
    send_tick(1'b0, 16'd250, 11'd1000);
    send_tick(1'b1, 16'd20, 11'd1);
    wait_drained();

    // inverted limits: the lower bound wins
    apply_cfg(16'd100, 16'd3, 16'd2, 16'd0, 16'd5000, 16'd1000, 16'd0);
    send_tick(1'b1, 16'd0, 11'd1080);
    send_tick(1'b1, 16'd65535, 11'd2);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      sp = 16'($urandom);
      if ($urandom_range(1)) begin
        kp = 16'($urandom_range(0, 30));
        kd = 16'($urandom_range(0, 30));
      end else begin
        kp = 16'($urandom_range(0, 9999));
        kd = 16'($urandom_range(0, 9999));
      end
      if (ph == 2) begin
        kp = 16'hFFFF;
        kd = 16'hFFFF;
      end
      if (ph == 4) kp = 16'd0;
      ms = (ph == 0) ? 16'd0 : (ph == 1) ? 16'd1080 : 16'($urandom_range(0, 1080));
      wa = 16'($urandom);
      wb = 16'($urandom);
      wmin = (wa < wb) ? wa : wb;
      wmax = (wa < wb) ? wb : wa;
      if (ph == 3) begin
        wmin = 16'd0;
        wmax = 16'hFFFF;
      end
      if (ph == 5) begin
        wmin = wmax;
        wmax = (wa < wb) ? wa : wb;
      end
      calm = (ph == 3);
      apply_cfg(sp, kp, kd, ms, wmin, wmax, 16'($urandom));
      for (int i = 0; i < TicksPerPhase; i++) begin
        if ($urandom_range(99) < 60) begin
          rng = drive_pred.setpoint + int'($urandom_range(0, 80)) - 40;
          if (rng < 0) rng = 0;
        end else begin
          rng = $urandom_range(0, 65535);
        end
        send_tick($urandom_range(99) < 85, 16'(rng),
                  11'($urandom_range(1080, drive_pred.min_supply)));
      end
      wait_drained();
    end
    calm = 1'b0;

    // lockout: threshold edge, the latching tick, then sticky low width
    apply_cfg(16'd120, 16'd5, 16'd5, 16'd500, 16'd1234, 16'd4000, 16'd3000);
    send_tick(1'b1, 16'd90, 11'd500);
    send_tick(1'b1, 16'd60, 11'd499);
    for (int i = 0; i < 12; i++)
      send_tick(1'($urandom_range(1)), 16'($urandom), 11'($urandom_range(0, 1080)));
    wait_drained();
    apply_cfg(16'd0, 16'd9999, 16'd9999, 16'hFFFF, 16'd0, 16'hFFFF, 16'd77);
    for (int i = 0; i < 12; i++)
      send_tick(1'($urandom_range(1)), 16'($urandom), 11'($urandom_range(0, 2047)));
    wait_drained();
    apply_cfg(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0);
    for (int i = 0; i < 6; i++)
      send_tick(1'($urandom_range(1)), 16'($urandom), 11'($urandom_range(0, 1080)));

    wait_drained();
    repeat (10) @(posedge clk);
    $display("tb_top: %0d ticks, %0d beats checked, %0d mismatches", drive_pred.n_ticks,
             drive_pred.n_beats, drive_pred.n_bad);
    $display("tb_top: neutral %0d, lockout %0d, clamp high %0d, clamp low %0d, linear %0d",
             drive_pred.n_neutral, drive_pred.n_lock, drive_pred.n_hi, drive_pred.n_lo,
             drive_pred.n_linear);
    if (drive_pred.n_bad == 0 && drive_pred.pending_results.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("tb_top: errors");
    $finish;
  end

endmodule

>>> files.f
design/rpdmd_pkg.sv
design/rpdmd_law.sv
design/range_pd_motor_drive_core.sv
dv/tb_top.sv
